// ----- hw/rtl/tshm_pkg.sv -----
package tshm_pkg;

  localparam int TimeW  = 64;
  localparam int VarW   = 32;
  localparam int SumW   = VarW + 2;
  localparam int SqW    = 2 * SumW;
  localparam int ThrW   = 84;
  localparam int EpochW = 32;
  localparam int QualW  = 7;

  // Where the quality of an item comes from once it reaches the output.
  localparam logic [1:0] QSRC_KEEP  = 2'd0;
  localparam logic [1:0] QSRC_ZERO  = 2'd1;
  localparam logic [1:0] QSRC_GRADE = 2'd2;

  localparam logic [QualW-1:0] Q_HIGH     = 7'd100;
  localparam logic [QualW-1:0] Q_MID_HIGH = 7'd66;
  localparam logic [QualW-1:0] Q_MID_LOW  = 7'd33;
  localparam logic [QualW-1:0] Q_NONE     = 7'd0;

  typedef struct packed {
    logic             cmd;
    logic [TimeW-1:0] now_us;
    logic [TimeW-1:0] sample_stamp_us;
    logic [VarW-1:0]  var_x;
    logic [VarW-1:0]  var_y;
    logic [VarW-1:0]  var_z;
    logic             vars_finite;
  } in_item_t;

  typedef struct packed {
    logic [31:0]     timeout_us;
    logic            cfg_ok;
    logic [ThrW-1:0] t1;
    logic [ThrW-1:0] t2;
    logic [ThrW-1:0] t3;
  } thresh_t;

  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic              changed;
    logic [1:0]        qsrc;
    logic [SumW-1:0]   sum;
  } track_t;

endpackage

// ----- hw/rtl/tshm_thresh.sv -----
module tshm_thresh (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata,
  output logic                busy,
  output tshm_pkg::thresh_t   thr
);

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_VSCALE  = 1'b1;
  localparam logic [2:0] SEQ_START = 3'd4;

  logic [31:0] timeout_us;
  logic [31:0] variance_scale;
  logic [2:0]  cnt;
  logic [63:0] vsq;
  logic [tshm_pkg::ThrW-1:0] t1, t2, t3;
  logic [tshm_pkg::ThrW-1:0] vsq_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us     <= 32'd100000;
      variance_scale <= 32'd65536;
      cnt            <= SEQ_START;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT: timeout_us     <= cfg_wdata;
        REG_VSCALE:  variance_scale <= cfg_wdata;
        default:     timeout_us     <= timeout_us;
      endcase
      cnt <= SEQ_START;
    end else if (cnt != 3'd0) begin
      cnt <= cnt - 3'd1;
    end
  end

  assign vsq_w = {20'd0, vsq};

  // The bounds are rebuilt one step a cycle: V*V, then times 90, then twice times 100.
  always_ff @(posedge clk) begin
    unique case (cnt)
      3'd4:    vsq <= 64'(variance_scale) * 64'(variance_scale);
      3'd3:    t1  <= (vsq_w << 6) + (vsq_w << 4) + (vsq_w << 3) + (vsq_w << 1);
      3'd2:    t2  <= (t1 << 6) + (t1 << 5) + (t1 << 2);
      3'd1:    t3  <= (t2 << 6) + (t2 << 5) + (t2 << 2);
      default: vsq <= vsq;
    endcase
  end

  assign busy           = (cnt != 3'd0);
  assign thr.timeout_us = timeout_us;
  assign thr.cfg_ok     = (timeout_us != 32'd0) && (variance_scale != 32'd0);
  assign thr.t1         = t1;
  assign thr.t2         = t2;
  assign thr.t3         = t3;

endmodule

// ----- hw/rtl/tshm_track.sv -----
module tshm_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  tshm_pkg::in_item_t   item,
  input  tshm_pkg::thresh_t    thr,
  output tshm_pkg::track_t     res
);

  logic [tshm_pkg::TimeW-1:0]  last_time, last_time_next;
  logic                        time_seen, time_seen_next;
  logic                        timed_out_flag, timed_out_flag_next;
  logic                        sample_seen, sample_seen_next;
  logic [tshm_pkg::TimeW-1:0]  last_stamp, last_stamp_next;
  logic [tshm_pkg::TimeW-1:0]  last_receive_time, last_receive_time_next;
  logic [tshm_pkg::EpochW-1:0] epoch_count, epoch_count_next;
  tshm_pkg::track_t            res_next;

  logic [tshm_pkg::EpochW-1:0] epoch_inc;
  logic [tshm_pkg::EpochW-1:0] epoch_adv;
  logic [tshm_pkg::TimeW:0]    limit_sum;
  logic [tshm_pkg::TimeW-1:0]  limit;
  logic                        bad;
  logic                        invalid;
  logic                        seen_w;

  assign epoch_inc = epoch_count + 32'd1;
  assign epoch_adv = (epoch_inc == 32'd0) ? 32'd1 : epoch_inc;
  assign limit_sum = {1'b0, last_receive_time} + {33'd0, thr.timeout_us};
  assign limit     = limit_sum[tshm_pkg::TimeW] ? {tshm_pkg::TimeW{1'b1}}
                                                : limit_sum[tshm_pkg::TimeW-1:0];
  assign bad       = !thr.cfg_ok || (time_seen && (item.now_us < last_time));
  assign invalid   = (item.sample_stamp_us == 64'd0) || !item.vars_finite ||
                     (item.var_x == 32'd0) || (item.var_y == 32'd0) ||
                     (item.var_z == 32'd0);

  always_comb begin
    last_time_next         = item.now_us;
    time_seen_next         = 1'b1;
    timed_out_flag_next    = timed_out_flag;
    sample_seen_next       = sample_seen;
    last_stamp_next        = last_stamp;
    last_receive_time_next = last_receive_time;
    epoch_count_next       = epoch_count;
    seen_w                 = sample_seen;
    res_next.changed       = 1'b0;
    res_next.qsrc          = tshm_pkg::QSRC_ZERO;
    res_next.sum           = 34'(item.var_x) + 34'(item.var_y) + 34'(item.var_z);
    if (item.cmd) begin
      if (bad) begin
        timed_out_flag_next = 1'b1;
        sample_seen_next    = 1'b0;
      end else if (!sample_seen || (item.now_us > limit)) begin
        timed_out_flag_next = 1'b1;
      end else begin
        res_next.qsrc = tshm_pkg::QSRC_KEEP;
      end
    end else if (bad) begin
      epoch_count_next    = epoch_adv;
      sample_seen_next    = 1'b0;
      timed_out_flag_next = 1'b1;
      res_next.changed    = 1'b1;
    end else begin
      // A return after a timeout opens the new epoch before the sample is judged,
      // so at most one epoch step happens per item.
      if (timed_out_flag) begin
        epoch_count_next    = epoch_adv;
        res_next.changed    = 1'b1;
        timed_out_flag_next = 1'b0;
        sample_seen_next    = 1'b0;
        seen_w              = 1'b0;
      end
      priority if (invalid) begin
        res_next.qsrc = tshm_pkg::QSRC_ZERO;
      end else if (seen_w && (item.sample_stamp_us < last_stamp)) begin
        epoch_count_next    = epoch_adv;
        sample_seen_next    = 1'b0;
        timed_out_flag_next = 1'b1;
        res_next.changed    = 1'b1;
      end else if (seen_w && (item.sample_stamp_us == last_stamp)) begin
        res_next.qsrc = tshm_pkg::QSRC_ZERO;
      end else begin
        sample_seen_next       = 1'b1;
        last_stamp_next        = item.sample_stamp_us;
        last_receive_time_next = item.now_us;
        res_next.qsrc          = tshm_pkg::QSRC_GRADE;
      end
    end
    res_next.epoch = epoch_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time         <= 64'd0;
      time_seen         <= 1'b0;
      timed_out_flag    <= 1'b0;
      sample_seen       <= 1'b0;
      last_stamp        <= 64'd0;
      last_receive_time <= 64'd0;
      epoch_count       <= 32'd0;
    end else if (load) begin
      last_time         <= last_time_next;
      time_seen         <= time_seen_next;
      timed_out_flag    <= timed_out_flag_next;
      sample_seen       <= sample_seen_next;
      last_stamp        <= last_stamp_next;
      last_receive_time <= last_receive_time_next;
      epoch_count       <= epoch_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

// ----- hw/rtl/tshm_grade.sv -----
module tshm_grade (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load_sq,
  input  logic                              load_out,
  input  tshm_pkg::track_t                  trk,
  input  tshm_pkg::thresh_t                 thr,
  output logic [tshm_pkg::EpochW-1:0]       epoch,
  output logic [tshm_pkg::QualW-1:0]        quality,
  output logic                              epoch_changed
);

  logic [tshm_pkg::SqW-1:0]    sq;
  logic [tshm_pkg::EpochW-1:0] epoch_sq;
  logic                        changed_sq;
  logic [1:0]                  qsrc_sq;
  logic [tshm_pkg::ThrW-1:0]   sq_w;
  logic [tshm_pkg::QualW-1:0]  graded;
  logic [tshm_pkg::QualW-1:0]  quality_next;

  always_ff @(posedge clk) begin
    if (load_sq) begin
      sq         <= tshm_pkg::SqW'(trk.sum) * tshm_pkg::SqW'(trk.sum);
      epoch_sq   <= trk.epoch;
      changed_sq <= trk.changed;
      qsrc_sq    <= trk.qsrc;
    end
  end

  // Comparing sum squared with 90, 9000 and 900000 times V squared grades mean = sum/3
  // against V times 10^0.5, 10^1.5 and 10^2.5 exactly; a tie falls to the lower level.
  assign sq_w = {{(tshm_pkg::ThrW - tshm_pkg::SqW){1'b0}}, sq};

  always_comb begin
    priority if (sq_w < thr.t1) begin
      graded = tshm_pkg::Q_HIGH;
    end else if (sq_w < thr.t2) begin
      graded = tshm_pkg::Q_MID_HIGH;
    end else if (sq_w < thr.t3) begin
      graded = tshm_pkg::Q_MID_LOW;
    end else begin
      graded = tshm_pkg::Q_NONE;
    end
    unique case (qsrc_sq)
      tshm_pkg::QSRC_GRADE: quality_next = graded;
      tshm_pkg::QSRC_KEEP:  quality_next = quality;
      default:              quality_next = tshm_pkg::Q_NONE;
    endcase
  end

  // The output quality register doubles as the kept quality level.
  always_ff @(posedge clk) begin
    if (rst) begin
      quality <= tshm_pkg::Q_NONE;
    end else if (load_out) begin
      quality <= quality_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      epoch         <= epoch_sq;
      epoch_changed <= changed_sq;
    end
  end

endmodule

// ----- hw/rtl/tracking_stream_health_monitor.sv -----
// Channel   Handshake              Payload
// input     in_valid / in_stall    cmd, now_us, sample_stamp_us, var_x/y/z, vars_finite
// output    out_valid / out_stall  epoch, quality, epoch_changed
// config    cfg_we                 cfg_index, cfg_wdata
//
// One item per cycle unless the output stalls or the bounds are rebuilt; each result
// passes the input register, the tracking stage, the squaring multiplier and the
// grading compares. After reset and after each configuration write, input is stalled
// while the quality bounds are rebuilt by the multiply-by-constant sequencer. A stalled
// output holds the pipeline; bubbles are squeezed out stage by stage.
module tracking_stream_health_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [63:0] now_us,
  input  logic [63:0] sample_stamp_us,
  input  logic [31:0] var_x,
  input  logic [31:0] var_y,
  input  logic [31:0] var_z,
  input  logic        vars_finite,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] epoch,
  output logic [6:0]  quality,
  output logic        epoch_changed,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  tshm_pkg::thresh_t  thr;
  tshm_pkg::in_item_t r0;
  tshm_pkg::track_t   trk;
  logic busy;
  logic v0, v1, v2;
  logic en0, en1, en2, en3;
  logic accept;

  assign en3    = !out_valid || !out_stall;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign en0    = !v0 || en1;
  assign in_stall = busy || !en0;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en0) v0 <= accept;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r0.cmd             <= cmd;
      r0.now_us          <= now_us;
      r0.sample_stamp_us <= sample_stamp_us;
      r0.var_x           <= var_x;
      r0.var_y           <= var_y;
      r0.var_z           <= var_z;
      r0.vars_finite     <= vars_finite;
    end
  end

  tshm_thresh u_thresh (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .thr       (thr)
  );

  tshm_track u_track (
    .clk  (clk),
    .rst  (rst),
    .load (v0 && en1),
    .item (r0),
    .thr  (thr),
    .res  (trk)
  );

  tshm_grade u_grade (
    .clk           (clk),
    .rst           (rst),
    .load_sq       (v1 && en2),
    .load_out      (v2 && en3),
    .trk           (trk),
    .thr           (thr),
    .epoch         (epoch),
    .quality       (quality),
    .epoch_changed (epoch_changed)
  );

`ifndef SYNTHESIS
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && epoch_changed |-> epoch != 32'd0)
    else $error("new epoch reported as zero");

  a_quality_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quality == tshm_pkg::Q_NONE) || (quality == tshm_pkg::Q_MID_LOW) ||
                  (quality == tshm_pkg::Q_MID_HIGH) || (quality == tshm_pkg::Q_HIGH))
    else $error("quality outside its four levels");

  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> in_stall)
    else $error("input taken while quality bounds are rebuilt");
`endif

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_VSCALE  = 1'b1;

  localparam logic [31:0] RESET_TIMEOUT = 32'd100000;
  localparam logic [31:0] RESET_VSCALE  = 32'h0001_0000;
  localparam logic [31:0] Q_ONE         = 32'h0001_0000;

  // Squared bounds: (3 * 10^k)^2 for k = 0.5, 1.5 and 2.5.
  localparam int unsigned BOUND_HIGH = 90;
  localparam int unsigned BOUND_MID  = 9000;
  localparam int unsigned BOUND_LOW  = 900000;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 200;

  typedef struct packed {
    logic [tshm_pkg::EpochW-1:0] epoch;
    logic [tshm_pkg::QualW-1:0]  quality;
    logic                        changed;
  } health_rpt_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = 1'b0;
  logic [63:0] now_us = '0;
  logic [63:0] sample_stamp_us = '0;
  logic [31:0] var_x = '0;
  logic [31:0] var_y = '0;
  logic [31:0] var_z = '0;
  logic        vars_finite = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] epoch;
  logic [6:0]  quality;
  logic        epoch_changed;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  tracking_stream_health_monitor u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .now_us          (now_us),
    .sample_stamp_us (sample_stamp_us),
    .var_x           (var_x),
    .var_y           (var_y),
    .var_z           (var_z),
    .vars_finite     (vars_finite),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .epoch           (epoch),
    .quality         (quality),
    .epoch_changed   (epoch_changed),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Tracking state mirrored from the block.
  logic [31:0]                 trk_timeout = RESET_TIMEOUT;
  logic [31:0]                 trk_vscale = RESET_VSCALE;
  logic [63:0]                 trk_last_time = '0;
  logic                        trk_time_seen = 1'b0;
  logic                        trk_timed_out = 1'b0;
  logic                        trk_sample_seen = 1'b0;
  logic [63:0]                 trk_last_stamp = '0;
  logic [63:0]                 trk_last_rx = '0;
  logic [tshm_pkg::EpochW-1:0] trk_epoch = '0;
  logic [tshm_pkg::QualW-1:0]  trk_quality = tshm_pkg::Q_NONE;

  health_rpt_t health_rpts[$];

  logic [63:0] stream_now = '0;
  logic [63:0] stream_stamp = 64'd1;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  bit          hold_req = 1'b0;
  int          stall_left = 0;

  int fail_count = 0;
  int n_ticks = 0;
  int n_samples = 0;
  int n_checked = 0;
  int n_changes = 0;
  int n_settings = 0;

  function automatic logic [tshm_pkg::EpochW-1:0] next_epoch(
      logic [tshm_pkg::EpochW-1:0] e);
    next_epoch = e + 1'b1;
    if (next_epoch == '0) next_epoch = 1;
  endfunction

  function automatic logic [tshm_pkg::QualW-1:0] grade_quality(
      logic [tshm_pkg::SumW-1:0] s);
    logic [127:0] sq;
    logic [127:0] v2;
    sq = 128'(s) * 128'(s);
    v2 = 128'(trk_vscale) * 128'(trk_vscale);
    if (sq < v2 * 128'(BOUND_HIGH)) return tshm_pkg::Q_HIGH;
    if (sq < v2 * 128'(BOUND_MID)) return tshm_pkg::Q_MID_HIGH;
    if (sq < v2 * 128'(BOUND_LOW)) return tshm_pkg::Q_MID_LOW;
    return tshm_pkg::Q_NONE;
  endfunction

  // Advances the mirrored tracking state by one item and returns its report.
  function automatic health_rpt_t judge_item(tshm_pkg::in_item_t it);
    health_rpt_t r;
    logic        bad;
    logic        changed;
    logic [64:0] lim_sum;
    logic [63:0] lim;
    bad = (trk_timeout == '0) || (trk_vscale == '0) ||
          (trk_time_seen && it.now_us < trk_last_time);
    changed = 1'b0;
    if (it.cmd == CMD_TICK) begin
      if (bad) begin
        trk_quality = tshm_pkg::Q_NONE;
        trk_timed_out = 1'b1;
        trk_sample_seen = 1'b0;
      end else begin
        lim_sum = {1'b0, trk_last_rx} + {33'd0, trk_timeout};
        lim = lim_sum[64] ? '1 : lim_sum[63:0];
        if (!trk_sample_seen || it.now_us > lim) begin
          trk_quality = tshm_pkg::Q_NONE;
          trk_timed_out = 1'b1;
        end
      end
      trk_last_time = it.now_us;
      trk_time_seen = 1'b1;
    end else begin
      trk_last_time = it.now_us;
      trk_time_seen = 1'b1;
      if (bad) begin
        trk_epoch = next_epoch(trk_epoch);
        trk_quality = tshm_pkg::Q_NONE;
        trk_sample_seen = 1'b0;
        trk_timed_out = 1'b1;
        changed = 1'b1;
      end else begin
        if (trk_timed_out) begin
          trk_epoch = next_epoch(trk_epoch);
          changed = 1'b1;
          trk_timed_out = 1'b0;
          trk_sample_seen = 1'b0;
        end
        if (it.sample_stamp_us == '0 || !it.vars_finite ||
            it.var_x == '0 || it.var_y == '0 || it.var_z == '0) begin
          trk_quality = tshm_pkg::Q_NONE;
        end else if (trk_sample_seen && it.sample_stamp_us < trk_last_stamp) begin
          trk_epoch = next_epoch(trk_epoch);
          trk_quality = tshm_pkg::Q_NONE;
          trk_sample_seen = 1'b0;
          trk_timed_out = 1'b1;
          changed = 1'b1;
        end else if (trk_sample_seen && it.sample_stamp_us == trk_last_stamp) begin
          trk_quality = tshm_pkg::Q_NONE;
        end else begin
          trk_sample_seen = 1'b1;
          trk_last_stamp = it.sample_stamp_us;
          trk_last_rx = it.now_us;
          trk_quality = grade_quality(tshm_pkg::SumW'(it.var_x) +
                                      tshm_pkg::SumW'(it.var_y) +
                                      tshm_pkg::SumW'(it.var_z));
        end
      end
    end
    r.epoch = trk_epoch;
    r.quality = trk_quality;
    r.changed = changed;
    return r;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Variances are placed around powers of ten of the reference so that all
  // four quality levels and the regions near their bounds come up.
  function automatic logic [31:0] gen_variance(logic [31:0] scale);
    logic [63:0] v;
    if ($urandom_range(0, 9) == 0) begin
      v = {32'd0, $urandom};
    end else begin
      v = {32'd0, scale};
      repeat ($urandom_range(0, 3)) v = v * 10;
      v = (v * $urandom_range(4, 64)) >> 4;
    end
    if (v == '0) v = 64'd1;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return v[31:0];
  endfunction

  function automatic tshm_pkg::in_item_t build_item(logic c, logic [63:0] t,
                                                    logic [63:0] stamp,
                                                    logic [31:0] vx, logic [31:0] vy,
                                                    logic [31:0] vz, logic fin);
    tshm_pkg::in_item_t it;
    it.cmd = c;
    it.now_us = t;
    it.sample_stamp_us = stamp;
    it.var_x = vx;
    it.var_y = vy;
    it.var_z = vz;
    it.vars_finite = fin;
    return it;
  endfunction

  task automatic make_random_item(output tshm_pkg::in_item_t it);
    int unsigned r;
    logic [31:0] span;
    r = $urandom_range(0, 99);
    span = (trk_timeout == '0) ? 32'd1000 : trk_timeout / 3;
    if (r < 4 && stream_now != '0) stream_now = stream_now - $urandom_range(1, 1000);
    else if (r < 6) stream_now = {$urandom, $urandom};
    else if (r < 14) stream_now = stream_now + trk_timeout + $urandom_range(1, 1000);
    else if (r < 30) stream_now = stream_now + $urandom_range(0, 3);
    else stream_now = stream_now + $urandom_range(0, span);
    it.now_us = stream_now;
    if ($urandom_range(0, 99) < 25) begin
      // The payload of a tick is ignored, so it carries garbage.
      it.cmd = CMD_TICK;
      it.sample_stamp_us = {$urandom, $urandom};
      it.var_x = $urandom;
      it.var_y = $urandom;
      it.var_z = $urandom;
      it.vars_finite = $urandom_range(0, 1);
    end else begin
      it.cmd = CMD_SAMPLE;
      r = $urandom_range(0, 99);
      if (r < 5) stream_stamp = stream_stamp;
      else if (r < 9) stream_stamp = stream_stamp - $urandom_range(1, 100);
      else if (r < 12) stream_stamp = {$urandom, $urandom};
      else stream_stamp = stream_stamp + $urandom_range(1, 5000);
      it.sample_stamp_us = ($urandom_range(0, 99) < 3) ? 64'd0 : stream_stamp;
      it.var_x = gen_variance(trk_vscale);
      it.var_y = gen_variance(trk_vscale);
      it.var_z = gen_variance(trk_vscale);
      if ($urandom_range(0, 99) < 4) begin
        case ($urandom_range(0, 2))
          0: it.var_x = '0;
          1: it.var_y = '0;
          default: it.var_z = '0;
        endcase
      end
      it.vars_finite = ($urandom_range(0, 99) >= 4);
    end
  endtask

  task automatic send_item(input tshm_pkg::in_item_t it);
    int gap;
    gap = (!tx_idle_en || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= it.cmd;
    now_us <= it.now_us;
    sample_stamp_us <= it.sample_stamp_us;
    var_x <= it.var_x;
    var_y <= it.var_y;
    var_z <= it.var_z;
    vars_finite <= it.vars_finite;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    health_rpts.push_back(judge_item(it));
    if (it.cmd == CMD_TICK) n_ticks++;
    else n_samples++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (health_rpts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TIMEOUT) trk_timeout = val;
    else trk_vscale = val;
  endtask

  task automatic set_config(input logic [31:0] tmo, input logic [31:0] scale);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_VSCALE, scale);
    n_settings++;
  endtask

  task automatic test_directed_tracking();
    send_item(build_item(CMD_TICK, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0));
    send_item(build_item(CMD_SAMPLE, 64'd10, 64'd5, Q_ONE, Q_ONE, Q_ONE, 1'b1));
    send_item(build_item(CMD_SAMPLE, 64'd20, 64'd6, 10 * Q_ONE, 10 * Q_ONE, 10 * Q_ONE, 1'b1));
    send_item(build_item(CMD_SAMPLE, 64'd30, 64'd7, 100 * Q_ONE, 100 * Q_ONE, 100 * Q_ONE,
                         1'b1));
    send_item(build_item(CMD_SAMPLE, 64'd40, 64'd8, '1, '1, '1, 1'b1));
    // Frozen stamp, then each kind of invalid sample.
    send_item(build_item(CMD_SAMPLE, 64'd50, 64'd8, Q_ONE, Q_ONE, Q_ONE, 1'b1));
    send_item(build_item(CMD_SAMPLE, 64'd51, 64'd0, Q_ONE, Q_ONE, Q_ONE, 1'b1));
    send_item(build_item(CMD_SAMPLE, 64'd52, 64'd9, 32'd0, Q_ONE, Q_ONE, 1'b1));
    send_item(build_item(CMD_SAMPLE, 64'd53, 64'd9, Q_ONE, 32'd0, Q_ONE, 1'b1));
    send_item(build_item(CMD_SAMPLE, 64'd54, 64'd9, Q_ONE, Q_ONE, 32'd0, 1'b1));
    send_item(build_item(CMD_SAMPLE, 64'd55, 64'd9, Q_ONE, Q_ONE, Q_ONE, 1'b0));
    // Stamp regression, then recovery with the smallest variances.
    send_item(build_item(CMD_SAMPLE, 64'd56, 64'd3, Q_ONE, Q_ONE, Q_ONE, 1'b1));
    send_item(build_item(CMD_TICK, 64'd60, 64'd0, 32'd0, 32'd0, 32'd0, 1'b1));
    send_item(build_item(CMD_SAMPLE, 64'd70, 64'd100, 32'd1, 32'd1, 32'd1, 1'b1));
    // Ticks right at and just past the timeout bound.
    send_item(build_item(CMD_TICK, 64'd100070, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0));
    send_item(build_item(CMD_TICK, 64'd100071, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0));
    send_item(build_item(CMD_SAMPLE, 64'd200000, 64'd101, Q_ONE, Q_ONE, Q_ONE, 1'b1));
    // Clock regressions on a tick and on a sample.
    send_item(build_item(CMD_TICK, 64'd100, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0));
    send_item(build_item(CMD_SAMPLE, 64'd50, 64'd102, Q_ONE, Q_ONE, Q_ONE, 1'b1));
  endtask

  task automatic test_invalid_config();
    set_config(32'd0, RESET_VSCALE);
    send_item(build_item(CMD_SAMPLE, 64'd300000, 64'd200, Q_ONE, Q_ONE, Q_ONE, 1'b1));
    send_item(build_item(CMD_TICK, 64'd300010, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0));
    set_config(RESET_TIMEOUT, 32'd0);
    send_item(build_item(CMD_SAMPLE, 64'd300020, 64'd201, Q_ONE, Q_ONE, Q_ONE, 1'b1));
    set_config(RESET_TIMEOUT, RESET_VSCALE);
    send_item(build_item(CMD_SAMPLE, 64'd300030, 64'd202, Q_ONE, Q_ONE, Q_ONE, 1'b1));
  endtask

  // With the receive time near the top of the range, the timeout bound must
  // saturate rather than wrap, or the tick would report a timeout.
  task automatic test_timeout_saturation();
    set_config('1, '1);
    send_item(build_item(CMD_SAMPLE, 64'hFFFF_FFFF_FFFF_FFF0, '1, '1, '1, '1, 1'b1));
    send_item(build_item(CMD_TICK, '1, '1, '1, '1, '1, 1'b1));
    send_item(build_item(CMD_SAMPLE, 64'd0, 64'd1, Q_ONE, Q_ONE, Q_ONE, 1'b1));
  endtask

  task automatic test_backpressure();
    tshm_pkg::in_item_t it;
    set_config(32'd5000, RESET_VSCALE);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    repeat (60) begin
      make_random_item(it);
      send_item(it);
    end
    wait_idle();
  endtask

  task automatic run_stream(input int n, input bit tx_idle, input bit rx_idle);
    tshm_pkg::in_item_t it;
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    if ($urandom_range(0, 1) == 1) stream_now = {$urandom, $urandom} >> $urandom_range(0, 40);
    stream_stamp = {$urandom, $urandom} >> $urandom_range(0, 40);
    repeat (n) begin
      make_random_item(it);
      send_item(it);
    end
    wait_idle();
  endtask

  task automatic test_random_streams();
    set_config(RESET_TIMEOUT, RESET_VSCALE);
    run_stream(200, 1'b0, 1'b0);
    set_config(32'd1, 32'd1);
    run_stream(150, 1'b1, 1'b1);
    set_config('1, '1);
    run_stream(200, 1'b1, 1'b0);
    repeat (3) begin
      set_config($urandom_range(1, 2000000), $urandom >> $urandom_range(0, 24));
      run_stream(150, 1'b1, 1'b1);
    end
    set_config(32'd0, RESET_VSCALE);
    run_stream(50, 1'b0, 1'b1);
    set_config(32'd5000, 32'd0);
    run_stream(50, 1'b1, 1'b0);
    set_config(32'd2000, 10 * Q_ONE);
    run_stream(200, 1'b1, 1'b1);
  endtask

  // The receiver stalls at random, or for one long hold when asked.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_reports
    health_rpt_t got;
    health_rpt_t want;
    if (!rst && out_valid && !out_stall) begin
      got.epoch = epoch;
      got.quality = quality;
      got.changed = epoch_changed;
      if (health_rpts.size() == 0) begin
        fail_count++;
        $display("%0t: report with no transfer pending: epoch %0d quality %0d changed %0b",
                 $time, got.epoch, got.quality, got.changed);
      end else begin
        want = health_rpts.pop_front();
        n_checked++;
        if (got.changed === 1'b1) n_changes++;
        if (got.epoch !== want.epoch) begin
          fail_count++;
          $display("%0t: epoch expected %0d actual %0d", $time, want.epoch, got.epoch);
        end
        if (got.quality !== want.quality) begin
          fail_count++;
          $display("%0t: quality expected %0d actual %0d", $time, want.quality, got.quality);
        end
        if (got.changed !== want.changed) begin
          fail_count++;
          $display("%0t: epoch_changed expected %0b actual %0b", $time, want.changed,
                   got.changed);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    n_settings = 1;
    test_directed_tracking();
    test_invalid_config();
    test_timeout_saturation();
    test_backpressure();
    test_random_streams();
    wait_idle();
    $display("Covered %0d transfers (%0d ticks, %0d samples) over %0d register settings.",
             n_ticks + n_samples, n_ticks, n_samples, n_settings);
    $display("Checked %0d reports, %0d of them opening a new epoch.", n_checked, n_changes);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d reports outstanding.", health_rpts.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- tracking_stream_health_monitor.f -----
hw/rtl/tshm_pkg.sv
hw/rtl/tshm_thresh.sv
hw/rtl/tshm_track.sv
hw/rtl/tshm_grade.sv
hw/rtl/tracking_stream_health_monitor.sv
tb/testbench.sv
